@@ src/u2d_pkg.sv @@
// ---------------------------------------------------------------------------
// u2d_pkg: shared types and constants
// Widths, digit count and the control word that drives the BCD cell row.
// ---------------------------------------------------------------------------
`default_nettype none

package u2d_pkg;

	localparam int VALUE_W    = 64;
	localparam int NUM_DIGITS = 20;
	localparam int CHAR_W     = 6;
	localparam int STEP_W     = 7;   // holds VALUE_W and NUM_DIGITS

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef logic [3:0] bcd_t;

	// control word broadcast to every cell
	typedef struct packed {
		logic clear;    // zero the digit
		logic dabble;   // add-3 adjust, shift in one binary bit
		logic shift;    // move digits one place toward the top
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/u2d_in_if.sv @@
// ---------------------------------------------------------------------------
// u2d_in_if: input channel
// valid/ready stream carrying one 64-bit value per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface u2d_in_if;
	import u2d_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);

endinterface

`default_nettype wire

@@ src/u2d_out_if.sv @@
// ---------------------------------------------------------------------------
// u2d_out_if: output channel
// valid/ready stream carrying one ASCII digit and a last flag per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface u2d_out_if;
	import u2d_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last_digit;

	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink   (input valid, input digit_char, input last_digit, output ready);

endinterface

`default_nettype wire

@@ src/u2d_cell.sv @@
// ---------------------------------------------------------------------------
// u2d_cell: one BCD digit of the conversion row
// Double dabble step (adjust by 3 at 5 or more, shift in a bit) or a plain
// digit shift toward the most significant end.
// ---------------------------------------------------------------------------
`default_nettype none

module u2d_cell
	import u2d_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       cin,    // bit from the lower neighbor
	input  wire bcd_t       din,    // digit from the lower neighbor
	output logic            cout,   // bit to the upper neighbor
	output bcd_t            dout
);

	bcd_t digit_q;
	bcd_t adj;

	always_comb begin
		adj = (digit_q >= 4'd5) ? bcd_t'(digit_q + 4'd3) : digit_q;
	end

	assign cout = adj[3];
	assign dout = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], cin};
		end else if (ctrl.shift) begin
			digit_q <= din;
		end
	end

endmodule

`default_nettype wire

@@ src/u64_to_decimal_ascii.sv @@
// ---------------------------------------------------------------------------
// u64_to_decimal_ascii: 64-bit unsigned to decimal ASCII digits
// Row of 20 BCD cells; double dabble, then digits leave most significant first.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer per number (value, 64 bits unsigned).
//   out_ch : one transfer per digit, most significant first, leading zeros
//            dropped; last_digit marks the final digit. Zero gives one '0'.
//   Each number takes one dabble step per binary bit through the cell row,
//   one bit per cycle, then one digit shift per digit out of the top cell
//   (leading zeros are shifted past, one per cycle, without a transfer).
//   The first digit follows the dabble steps and the shifts past leading
//   zeros. in_ch.ready is high only between items.
//   A stalled receiver holds the output register; the cell row waits with
//   it. The next input may be taken while the last digit still waits.
//   Reset (arst_n low) returns the control to idle and drops any pending
//   output; the digit cells need no reset.
// ---------------------------------------------------------------------------
`default_nettype none

module u64_to_decimal_ascii
	import u2d_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	u2d_in_if.sink     in_ch,
	u2d_out_if.source  out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DABBLE = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [VALUE_W-1:0] bin_q;
	logic               started_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	cell_ctrl_t ctrl;
	logic       cy   [NUM_DIGITS];
	bcd_t       dg   [NUM_DIGITS];
	bcd_t       top_digit;
	logic       skip;
	logic       emit_fire;
	logic       in_fire;
	logic       is_last;

	assign top_digit = dg[NUM_DIGITS-1];
	assign in_fire   = in_ch.valid && in_ch.ready;
	assign is_last   = (cnt_q == STEP_W'(1));

	// leading zero: shift past it unless it is the only digit left
	assign skip      = (state_q == ST_EMIT) && !started_q && (top_digit == 4'd0) && !is_last;
	assign emit_fire = (state_q == ST_EMIT) && !skip && (!out_valid_q || out_ch.ready);

	always_comb begin
		ctrl.clear  = in_fire;
		ctrl.dabble = (state_q == ST_DABBLE);
		ctrl.shift  = skip || emit_fire;
	end

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		logic cin_w;
		bcd_t din_w;
		if (i == 0) begin : g_lo
			assign cin_w = bin_q[VALUE_W-1];
			assign din_w = '0;
		end else begin : g_up
			assign cin_w = cy[i-1];
			assign din_w = dg[i-1];
		end
		u2d_cell u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.cin  (cin_w),
			.din  (din_w),
			.cout (cy[i]),
			.dout (dg[i])
		);
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_DABBLE;
						cnt_q   <= STEP_W'(VALUE_W);
					end
				end
				ST_DABBLE: begin
					if (cnt_q == STEP_W'(1)) begin
						state_q   <= ST_EMIT;
						cnt_q     <= STEP_W'(NUM_DIGITS);
						started_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q - STEP_W'(1);
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						started_q <= 1'b1;
					end
					if (skip || emit_fire) begin
						cnt_q <= cnt_q - STEP_W'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bin_q <= in_ch.value;
		end else if (state_q == ST_DABBLE) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
		if (emit_fire) begin
			out_char_q <= ASCII_ZERO + {2'b00, top_digit};
			out_last_q <= is_last;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.digit_char = out_char_q;
	assign out_ch.last_digit = out_last_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench for u64_to_decimal_ascii
// Feeds 64-bit numbers through the input stream and checks every digit
// transfer against an in-bench decimal conversion, with random gaps on
// the input side and random back-pressure on the output side.
// ---------------------------------------------------------------------------

module tb;
	import u2d_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_rec_t;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;

	u2d_in_if  in_ch ();
	u2d_out_if out_ch ();

	u64_to_decimal_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	logic [VALUE_W-1:0] pending_values [$];
	digit_rec_t         expected_digits [$];

	logic in_fire;
	int   in_gap_left;
	int   out_stall_left;
	int   calm_left;
	int   numbers_taken;
	int   mismatch_count;
	int   idle_cycles;

	// mostly zero or short gaps, a few long ones, and runs with none at all
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_left = $urandom_range(8, 30);
			return 0;
		end else if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(8, 60);
		end
	endfunction

	// decimal digits of one number, most significant first, no leading zeros
	function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] number);
		logic [3:0]         lsd_first [NUM_DIGITS];
		logic [VALUE_W-1:0] rest;
		int                 count;
		digit_rec_t         rec;
		rest = number;
		count = 0;
		do begin
			lsd_first[count] = 4'(rest % 64'd10);
			rest = rest / 64'd10;
			count++;
		end while (rest != 0 && count < NUM_DIGITS);
		for (int k = count - 1; k >= 0; k--) begin
			rec.digit_char = ASCII_ZERO + {2'b00, lsd_first[k]};
			rec.last_digit = (k == 0);
			expected_digits.push_back(rec);
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// input driver: hold valid until the transfer, then gap or next number
	always @(negedge clk) begin
		if (arst_n && !(in_ch.valid && !in_fire)) begin
			if (in_gap_left > 0) begin
				in_ch.valid <= 1'b0;
				in_gap_left--;
			end else if (pending_values.size() != 0) begin
				in_ch.valid <= 1'b1;
				in_ch.value <= pending_values.pop_front();
				in_gap_left = pick_gap();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// output back-pressure
	always @(negedge clk) begin
		if (out_stall_left > 0) begin
			out_ch.ready <= 1'b0;
			out_stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				out_stall_left = pick_gap();
		end
	end

	// monitor: predict on input transfers, check on output transfers
	always @(posedge clk) begin
		digit_rec_t want;
		in_fire <= in_ch.valid && in_ch.ready;
		if (arst_n) begin
			idle_cycles++;
			if (in_ch.valid && in_ch.ready) begin
				queue_decimal_digits(in_ch.value);
				numbers_taken++;
				idle_cycles = 0;
			end
			if (out_ch.valid && out_ch.ready) begin
				idle_cycles = 0;
				if (expected_digits.size() == 0) begin
					if (mismatch_count < 10)
						$display("tb: unexpected digit %0d last %0b",
							out_ch.digit_char, out_ch.last_digit);
					mismatch_count++;
				end else begin
					want = expected_digits.pop_front();
					if (out_ch.digit_char !== want.digit_char ||
						out_ch.last_digit !== want.last_digit) begin
						if (mismatch_count < 10)
							$display("tb: digit mismatch: want %0d last %0b, got %0d last %0b",
								want.digit_char, want.last_digit,
								out_ch.digit_char, out_ch.last_digit);
						mismatch_count++;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] raw;
		logic [VALUE_W-1:0] pow10;
		int                 total_numbers;
		int                 bits;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
		in_fire = 1'b0;
		in_gap_left = 0;
		out_stall_left = 0;
		calm_left = 0;
		numbers_taken = 0;
		mismatch_count = 0;
		idle_cycles = 0;

		// zero, one digit, digit-count boundaries, the largest value
		pending_values = '{
			64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd12345,
			64'd999999999, 64'd1000000000, 64'd4294967295, 64'd4294967296,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'd9999999999999999999, 64'd10000000000000000000,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF
		};

		for (int i = 0; i < 81; i++) begin
			raw = {$urandom(), $urandom()};
			case ($urandom_range(0, 5))
				0: pending_values.push_back(raw);
				1: begin
					// just around a power of ten, where the digit count steps
					pow10 = 64'd1;
					repeat ($urandom_range(1, 19)) pow10 = pow10 * 64'd10;
					pending_values.push_back(pow10 + 64'($urandom_range(0, 2)) - 64'd1);
				end
				default: begin
					bits = $urandom_range(1, VALUE_W);
					pending_values.push_back(raw >> (VALUE_W - bits));
				end
			endcase
		end
		total_numbers = pending_values.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (numbers_taken < total_numbers)
			@(posedge clk);
		while (expected_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_digits.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
src/u2d_pkg.sv
src/u2d_in_if.sv
src/u2d_out_if.sv
src/u2d_cell.sv
src/u64_to_decimal_ascii.sv
tb/tb.sv
